>>> rtl/mti_pkg.sv
// Shared types and constants for the magnetotelluric impedance tensor block.
`timescale 1ns / 1ps

package mti_pkg;

    // Default component format
    localparam int COMPONENT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF      = 16;

    // Each packed complex word holds two halves of this width
    localparam int HALF_BITS = 32;

    // Quotient lanes: real and imaginary part of Zxx, Zxy, Zyx, Zyy
    localparam int N_LANES = 8;

    typedef struct packed {
        logic [63:0] ex_pol0;
        logic [63:0] ey_pol0;
        logic [63:0] hx_pol0;
        logic [63:0] hy_pol0;
        logic [63:0] ex_pol1;
        logic [63:0] ey_pol1;
        logic [63:0] hx_pol1;
        logic [63:0] hy_pol1;
    } t_in_req;

    typedef struct packed {
        logic [63:0] z_xx;
        logic [63:0] z_xy;
        logic [63:0] z_yx;
        logic [63:0] z_yy;
        logic        singular;
        logic        saturated;
    } t_out_rsp;

endpackage

>>> rtl/mti_front.sv
// Front end: complex cross products forming the determinant and four numerators.
`timescale 1ns / 1ps

module mti_front #(
    parameter int  CB = mti_pkg::COMPONENT_BITS_DEF,
    localparam int S  = 2 * CB + 2,
    localparam int P  = 2 * CB
) (
    input  logic                i_clk,
    input  logic [1:0]          i_en,
    input  mti_pkg::t_in_req    i_req,
    output logic signed [S-1:0] o_re [5],
    output logic signed [S-1:0] o_im [5]
);

    // Operand selection per cross a*b - c*d; slot 0 is the determinant.
    // Field order: ex0, ey0, hx0, hy0, ex1, ey1, hx1, hy1
    localparam logic [2:0] SEL_A [5] = '{3'd2, 3'd0, 3'd4, 3'd1, 3'd5};
    localparam logic [2:0] SEL_B [5] = '{3'd7, 3'd7, 3'd2, 3'd7, 3'd2};
    localparam logic [2:0] SEL_C [5] = '{3'd3, 3'd4, 3'd0, 3'd5, 3'd1};
    localparam logic [2:0] SEL_D [5] = '{3'd6, 3'd3, 3'd6, 3'd3, 3'd6};

    logic [63:0]         fld   [8];
    logic signed [CB-1:0] c_re [8];
    logic signed [CB-1:0] c_im [8];
    logic signed [P-1:0] n_m   [5][8];
    logic signed [P-1:0] r_m   [5][8];
    logic signed [S-1:0] n_re  [5];
    logic signed [S-1:0] n_im  [5];
    logic signed [S-1:0] r_re  [5];
    logic signed [S-1:0] r_im  [5];

    assign fld[0] = i_req.ex_pol0;
    assign fld[1] = i_req.ey_pol0;
    assign fld[2] = i_req.hx_pol0;
    assign fld[3] = i_req.hy_pol0;
    assign fld[4] = i_req.ex_pol1;
    assign fld[5] = i_req.ey_pol1;
    assign fld[6] = i_req.hx_pol1;
    assign fld[7] = i_req.hy_pol1;

    // Unpack components from the low bits of each half
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            c_re[k] = fld[k][mti_pkg::HALF_BITS +: CB];
            c_im[k] = fld[k][0 +: CB];
        end
    end

    // Form all real partial products
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            n_m[j][0] = c_re[SEL_A[j]] * c_re[SEL_B[j]];
            n_m[j][1] = c_im[SEL_A[j]] * c_im[SEL_B[j]];
            n_m[j][2] = c_re[SEL_A[j]] * c_im[SEL_B[j]];
            n_m[j][3] = c_im[SEL_A[j]] * c_re[SEL_B[j]];
            n_m[j][4] = c_re[SEL_C[j]] * c_re[SEL_D[j]];
            n_m[j][5] = c_im[SEL_C[j]] * c_im[SEL_D[j]];
            n_m[j][6] = c_re[SEL_C[j]] * c_im[SEL_D[j]];
            n_m[j][7] = c_im[SEL_C[j]] * c_re[SEL_D[j]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m <= n_m;
        end
    end

    // Combine products into complex differences
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            n_re[j] = S'(r_m[j][0]) - S'(r_m[j][1]) - S'(r_m[j][4]) + S'(r_m[j][5]);
            n_im[j] = S'(r_m[j][2]) + S'(r_m[j][3]) - S'(r_m[j][6]) - S'(r_m[j][7]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_re <= n_re;
            r_im <= n_im;
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;

endmodule

>>> rtl/mti_dot.sv
// Wide signed a*b + c*d built from split partial products over two stages.
`timescale 1ns / 1ps

module mti_dot #(
    parameter int  CB = mti_pkg::COMPONENT_BITS_DEF,
    localparam int S  = 2 * CB + 2,
    localparam int H  = S / 2,
    localparam int W  = 2 * S + 1
) (
    input  logic                i_clk,
    input  logic [1:0]          i_en,
    input  logic signed [S-1:0] i_a,
    input  logic signed [S-1:0] i_b,
    input  logic signed [S-1:0] i_c,
    input  logic signed [S-1:0] i_d,
    output logic signed [W-1:0] o_y
);

    logic signed [H:0]     ah, al, bh, bl, ch, cl, dh, dl;
    logic signed [2*H+1:0] n_pp [8];
    logic signed [2*H+1:0] r_pp [8];
    logic signed [W-1:0]   n_y;
    logic signed [W-1:0]   r_y;

    function automatic logic signed [W-1:0] ext(input logic signed [2*H+1:0] v);
        return W'(v);
    endfunction

    // Split each operand into a signed high half and an unsigned low half
    assign ah = {i_a[S-1], i_a[S-1:H]};
    assign al = {1'b0, i_a[H-1:0]};
    assign bh = {i_b[S-1], i_b[S-1:H]};
    assign bl = {1'b0, i_b[H-1:0]};
    assign ch = {i_c[S-1], i_c[S-1:H]};
    assign cl = {1'b0, i_c[H-1:0]};
    assign dh = {i_d[S-1], i_d[S-1:H]};
    assign dl = {1'b0, i_d[H-1:0]};

    // Partial products
    always_comb begin
        n_pp[0] = ah * bh;
        n_pp[1] = ah * bl;
        n_pp[2] = al * bh;
        n_pp[3] = al * bl;
        n_pp[4] = ch * dh;
        n_pp[5] = ch * dl;
        n_pp[6] = cl * dh;
        n_pp[7] = cl * dl;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pp <= n_pp;
        end
    end

    // Align and sum the partial products
    always_comb begin
        n_y = (ext(r_pp[0]) <<< S) + ((ext(r_pp[1]) + ext(r_pp[2])) <<< H) + ext(r_pp[3])
            + (ext(r_pp[4]) <<< S) + ((ext(r_pp[5]) + ext(r_pp[6])) <<< H) + ext(r_pp[7]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

>>> rtl/mti_div.sv
// Pipelined restoring divider: one quotient bit per stage, with saturation.
`timescale 1ns / 1ps

module mti_div #(
    parameter int  CB = mti_pkg::COMPONENT_BITS_DEF,
    parameter int  FB = mti_pkg::FRAC_BITS_DEF,
    localparam int W  = 4 * CB + 5,
    localparam int WX = W + FB,
    localparam int WC = WX + CB,
    localparam int NL = mti_pkg::N_LANES
) (
    input  logic                 i_clk,
    input  logic [CB+1:0]        i_en,
    input  logic signed [W-1:0]  i_num [NL],
    input  logic [W-1:0]         i_den,
    output logic [CB-1:0]        o_val [NL],
    output logic                 o_sat [NL]
);

    localparam logic [CB-1:0] MAX_POS = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] MAX_NEG = {1'b1, {(CB-1){1'b0}}};

    logic [WX-1:0] r_rem [0:CB][NL];
    logic [CB-1:0] r_q   [0:CB][NL];
    logic          r_neg [0:CB][NL];
    logic          r_big [0:CB][NL];
    logic [W-1:0]  r_den [0:CB-1];

    logic [WX-1:0] n_rem0 [NL];
    logic          n_neg0 [NL];
    logic          n_big0 [NL];
    logic [WX-1:0] n_rem  [1:CB][NL];
    logic [CB-1:0] n_q    [1:CB][NL];

    logic [CB-1:0] n_val [NL];
    logic          n_sat [NL];
    logic [CB-1:0] r_val [NL];
    logic          r_sat [NL];

    // Take magnitude, scale, and flag quotients that cannot fit
    always_comb begin
        logic [W-1:0] mag;
        mag = '0;
        for (int l = 0; l < NL; l++) begin
            n_neg0[l] = i_num[l][W-1];
            mag       = n_neg0[l] ? $unsigned(-i_num[l]) : $unsigned(i_num[l]);
            n_rem0[l] = WX'(mag) << FB;
            n_big0[l] = WC'(n_rem0[l]) >= (WC'(i_den) << CB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= n_rem0;
            r_neg[0] <= n_neg0;
            r_big[0] <= n_big0;
            r_den[0] <= i_den;
            for (int l = 0; l < NL; l++) begin
                r_q[0][l] <= '0;
            end
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= CB; k++) begin : g_step
        localparam int B = CB - k;

        always_comb begin
            logic [WC-1:0] dk;
            logic [WC-1:0] rk;
            logic          ge;
            dk = WC'(r_den[k-1]) << B;
            rk = '0;
            ge = 1'b0;
            for (int l = 0; l < NL; l++) begin
                rk          = WC'(r_rem[k-1][l]);
                ge          = rk >= dk;
                n_rem[k][l] = ge ? WX'(rk - dk) : r_rem[k-1][l];
                n_q[k][l]   = r_q[k-1][l] | (CB'(ge) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_neg[k] <= r_neg[k-1];
                r_big[k] <= r_big[k-1];
            end
        end

        // Carry the divisor only as far as a later stage needs it
        if (k < CB) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    // Clamp to the component range and apply the sign
    always_comb begin
        logic [CB-1:0] lim;
        logic [CB-1:0] mag;
        lim = '0;
        mag = '0;
        for (int l = 0; l < NL; l++) begin
            lim      = r_neg[CB][l] ? MAX_NEG : MAX_POS;
            n_sat[l] = r_big[CB][l] || (r_q[CB][l] > lim);
            mag      = n_sat[l] ? lim : r_q[CB][l];
            n_val[l] = r_neg[CB][l] ? (CB'(0) - mag) : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[CB+1]) begin
            r_val <= n_val;
            r_sat <= n_sat;
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

>>> rtl/mt_impedance_tensor.sv
// Throughput: one request per cycle unless an output stall backs up to the input;
// the divider retires one quotient bit per stage, so the divider stages make up
// most of the latency.
// A stall holds only occupied stages; bubbles upstream keep filling.
// Reset (synchronous, active low) empties the pipeline and clears min_det_sq to zero.
`timescale 1ns / 1ps

module mt_impedance_tensor #(
    parameter int COMPONENT_BITS = mti_pkg::COMPONENT_BITS_DEF,
    parameter int FRAC_BITS      = mti_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mti_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output mti_pkg::t_out_rsp o_rsp,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata
);

    localparam int CB = COMPONENT_BITS;
    localparam int S  = 2 * CB + 2;
    localparam int W  = 2 * S + 1;
    localparam int L  = CB + 6;
    localparam int WT = W + 3 * FRAC_BITS + 32;
    localparam int HB = mti_pkg::HALF_BITS;
    localparam int NL = mti_pkg::N_LANES;

    logic [L-1:0]        en;
    logic [L-1:0]        r_vld, n_vld;
    logic [L-1:4]        r_sing, n_sing;
    logic [31:0]         r_min_det_sq;

    logic signed [S-1:0] f_re [5];
    logic signed [S-1:0] f_im [5];
    logic signed [S-1:0] neg_di;
    logic signed [W-1:0] w_dsq;
    logic signed [W-1:0] w_num [NL];
    logic [CB-1:0]       w_val [NL];
    logic                w_sat [NL];
    logic                sing_cmp;
    logic                any_sat;
    logic [HB-1:0]       w_half [NL];

    // Per-stage advance: a stage moves if empty or its successor moves
    always_comb begin
        en[L-1] = !r_vld[L-1] || !i_stall;
        for (int k = L - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[L-1];

    // Advance valid and singular flags with the data
    assign n_vld  = {r_vld[L-2:0], i_valid};
    assign n_sing = {r_sing[L-2:4], sing_cmp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_sing       <= '0;
            r_min_det_sq <= '0;
        end else begin
            r_vld  <= (en & n_vld) | (~en & r_vld);
            r_sing <= (en[L-1:4] & n_sing) | (~en[L-1:4] & r_sing);
            if (i_cfg_we) begin
                r_min_det_sq <= i_cfg_wdata;
            end
        end
    end

    // Determinant and numerators
    mti_front #(.CB(CB)) u_front (
        .i_clk (i_clk),
        .i_en  (en[1:0]),
        .i_req (i_req),
        .o_re  (f_re),
        .o_im  (f_im)
    );

    assign neg_di = -f_im[0];

    // |det|^2
    mti_dot #(.CB(CB)) u_dot_dsq (
        .i_clk (i_clk),
        .i_en  (en[3:2]),
        .i_a   (f_re[0]),
        .i_b   (f_re[0]),
        .i_c   (f_im[0]),
        .i_d   (f_im[0]),
        .o_y   (w_dsq)
    );

    // N * conj(det), real and imaginary parts per tensor entry
    for (genvar j = 1; j < 5; j++) begin : g_num
        mti_dot #(.CB(CB)) u_dot_re (
            .i_clk (i_clk),
            .i_en  (en[3:2]),
            .i_a   (f_re[j]),
            .i_b   (f_re[0]),
            .i_c   (f_im[j]),
            .i_d   (f_im[0]),
            .o_y   (w_num[2*(j-1)])
        );

        mti_dot #(.CB(CB)) u_dot_im (
            .i_clk (i_clk),
            .i_en  (en[3:2]),
            .i_a   (f_im[j]),
            .i_b   (f_re[0]),
            .i_c   (f_re[j]),
            .i_d   (neg_di),
            .o_y   (w_num[2*(j-1)+1])
        );
    end

    // Singular test against the scaled threshold
    assign sing_cmp = WT'($unsigned(w_dsq)) <= (WT'(r_min_det_sq) << (3 * FRAC_BITS));

    mti_div #(.CB(CB), .FB(FRAC_BITS)) u_div (
        .i_clk (i_clk),
        .i_en  (en[L-1:4]),
        .i_num (w_num),
        .i_den ($unsigned(w_dsq)),
        .o_val (w_val),
        .o_sat (w_sat)
    );

    // Pack the result; zero the tensor and the saturation flag on a singular determinant
    always_comb begin
        any_sat = 1'b0;
        for (int l = 0; l < NL; l++) begin
            any_sat   = any_sat | w_sat[l];
            w_half[l] = r_sing[L-1] ? '0 : HB'(w_val[l]);
        end
        o_rsp.z_xx      = {w_half[0], w_half[1]};
        o_rsp.z_xy      = {w_half[2], w_half[3]};
        o_rsp.z_yx      = {w_half[4], w_half[5]};
        o_rsp.z_yy      = {w_half[6], w_half[7]};
        o_rsp.singular  = r_sing[L-1];
        o_rsp.saturated = !r_sing[L-1] && any_sat;
    end

endmodule

>>> rtl/mti_checker.sv
// Port-level checker for the impedance tensor block and its bind.
`timescale 1ns / 1ps

module mti_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input mti_pkg::t_out_rsp o_rsp
);

    // Held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rsp)))
        else $error("result changed while stalled");

    // Input back-pressure only when the output is full and stalled
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("request stalled with room in the pipeline");

    // Singular result carries a zero tensor and no saturation
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.singular) |-> (o_rsp.z_xx == '0 && o_rsp.z_xy == '0 &&
            o_rsp.z_yx == '0 && o_rsp.z_yy == '0 && !o_rsp.saturated))
        else $error("singular result with nonzero tensor");

    // Reset empties the pipeline
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind mt_impedance_tensor mti_checker u_mti_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);
